FILE: rtl/core/fgo_pkg.sv
// fgo_pkg: shared widths, types and the sine table builder for the formant
// grain oscillator. No dependencies; every rtl/core module imports it.
package fgo_pkg;

   localparam int CHANNELS         = 16;
   localparam int CH_IDX_W         = $clog2(CHANNELS);
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);

   localparam int CH_W     = 4;
   localparam int FREQ_W   = 24;
   localparam int SAMPLE_W = 16;
   localparam int RATE_W   = 32;
   localparam int INC_W    = 33;        // increments capped at 1.0 in Q32
   localparam int PH34_W   = 34;
   localparam int PH32_W   = 32;
   localparam int MUL_W    = 34;        // signed operand width of the shared multiplier
   localparam int PROD_W   = 2 * MUL_W;
   localparam int DVD_W    = 66;        // dividend / quotient width
   localparam int DVS_W    = INC_W;     // divisor width
   localparam int DIV_CNT_W = $clog2(DVD_W + 1);

   localparam logic [RATE_W-1:0] INV_RATE_RESET = 32'd1431656;
   localparam logic [63:0]       TWO_PI_Q30     = 64'd6746518852;

   typedef logic signed [SAMPLE_W-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // sine table in Q15, integer Taylor series per quarter wave
   function automatic sine_rom_type build_sine();
      sine_rom_type     tab;
      logic [63:0]      p;
      logic [63:0]      quarter;
      logic [63:0]      f;
      logic [63:0]      x;
      logic [63:0]      x2;
      logic [63:0]      term;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         p       = ((64'(k) << 32) / SINE_TABLE_DEPTH) & 64'hFFFF_FFFF;
         quarter = p >> 30;
         f       = p & 64'h3FFF_FFFF;
         if (quarter[0]) begin
            f = (64'd1 << 30) - f;
         end
         x    = (f * TWO_PI_Q30) >> 32;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (sum + 64'sd16384) >>> 15;
         if (r > 64'sd32767) begin
            r = 64'sd32767;
         end
         tab[k] = quarter[1] ? SAMPLE_W'(-r) : SAMPLE_W'(r);
      end
      return tab;
   endfunction

endpackage

FILE: rtl/core/fgo_mul.sv
// fgo_mul: the shared signed multiplier, product registered.
// Depends on fgo_pkg.
module fgo_mul (
   input  logic                               clock,
   input  logic                               mul_en,
   input  logic signed [fgo_pkg::MUL_W-1:0]   mul_a,
   input  logic signed [fgo_pkg::MUL_W-1:0]   mul_b,
   output logic signed [fgo_pkg::PROD_W-1:0]  mul_p
);
   import fgo_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   // product holds until the next issue
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign mul_p = prod_ff;

endmodule

FILE: rtl/core/fgo_div.sv
// fgo_div: restoring divider, one quotient bit per cycle.
// Depends on fgo_pkg.
module fgo_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         div_start,
   input  logic [fgo_pkg::DVD_W-1:0]    div_dividend,
   input  logic [fgo_pkg::DVS_W-1:0]    div_divisor,
   output logic [fgo_pkg::DVD_W-1:0]    div_quotient,
   output fgo_pkg::div_status_type      div_stat
);
   import fgo_pkg::*;

   logic [DVD_W-1:0]     dvd_ff;     // shifts dividend out, quotient in
   logic [DVS_W-1:0]     dvs_ff;
   logic [DVS_W:0]       rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DVS_W+1:0]     rem_sh;
   logic [DVS_W+1:0]     rem_sub;
   logic                 qbit;

   // one trial subtract per step
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      rem_sub = rem_sh - {2'b00, dvs_ff};
      qbit    = (rem_sh >= {2'b00, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DVD_W);
            dvd_ff  <= div_dividend;
            dvs_ff  <= div_divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= qbit ? rem_sub[DVS_W:0] : rem_sh[DVS_W:0];
            dvd_ff <= {dvd_ff[DVD_W-2:0], qbit};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_quotient  = dvd_ff;
   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;

endmodule

FILE: rtl/core/fgo_sine_rom.sv
// fgo_sine_rom: Q15 sine table with registered read.
// Depends on fgo_pkg (table builder).
module fgo_sine_rom (
   input  logic                                 clock,
   input  logic [fgo_pkg::SINE_ADDR_W-1:0]      rom_addr,
   output logic signed [fgo_pkg::SAMPLE_W-1:0]  rom_q
);
   import fgo_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine();

   logic signed [SAMPLE_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      q_ff <= SINE_ROM[rom_addr];
   end

   assign rom_q = q_ff;

endmodule

FILE: rtl/core/formant_grain_oscillator_top.sv
// Formant grain oscillator top level: sequencer, per-channel phase state and
// the shared multiplier / divider. Depends on fgo_pkg, fgo_mul, fgo_div, fgo_sine_rom.
//
// Usage:
//   req channel: tuser = channel, tdata = fund, center, band frequencies (Q4 Hz).
//   rsp channel: tuser = channel, tdata = Q1.15 sample. One result per transaction.
//   csr_wen/csr_wdata write inverse_rate (2^36 / sample rate); write only when idle.
// Sequencing: one transaction at a time. A closed window skips the sine reads. A
//   fundamental wrap with a nonzero fundamental increment adds two serial
//   divisions of a 66-bit dividend on the shared divider. Sine reads go through
//   one registered ROM port, four reads per item with the window open, and
//   every multiply uses the one registered 34x34 multiplier.
// req_tready is high only while the sequencer is idle. A finished result sits
//   in the rsp output register; the next transaction is accepted meanwhile, and
//   its result waits until rsp is taken.
// Reset (synchronous): fundamental phases to 1.0, carrier and window phases to
//   zero, inverse_rate to its default, output empty.
module formant_grain_oscillator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [71:0]                     req_tdata,   // fund_freq, center_freq, band_freq
   input  logic [fgo_pkg::CH_W-1:0]        req_tuser,   // channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fgo_pkg::SAMPLE_W-1:0]    rsp_tdata,   // sample
   output logic [fgo_pkg::CH_W-1:0]        rsp_tuser,   // out_channel
   input  logic                            csr_wen,
   input  logic [fgo_pkg::RATE_W-1:0]      csr_wdata    // inverse_rate
);
   import fgo_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_INC_F, S_INC_B, S_INC_C, S_LOAD, S_WRAP, S_Q_START, S_Q_WAIT,
      S_W_START, S_W_WAIT, S_WIN, S_RD_A, S_RD_B, S_INTERP, S_SINE, S_PROD,
      S_SAMPLE, S_UPDATE, S_DONE
   } state_type;

   localparam logic [PH34_W-1:0] ONE_Q32     = 34'h1_0000_0000;
   localparam logic [PH34_W-1:0] PHASE34_MAX = {PH34_W{1'b1}};
   localparam logic [PH32_W-1:0] HANN_OFFSET = 32'hC000_0000;

   state_type state_ff, state_in;

   logic [RATE_W-1:0]     inv_rate_ff;
   logic [CH_W-1:0]       ch_ff;
   logic                  ch_ok_ff;
   logic [FREQ_W-2:0]     fund_ff;
   logic [FREQ_W-2:0]     bw_ff;
   logic [FREQ_W-1:0]     cf_mag_ff;
   logic                  cf_neg_ff;
   logic [INC_W-1:0]      finc_ff;
   logic [INC_W-1:0]      binc_ff;
   logic [INC_W-1:0]      cinc_ff;
   logic [PH34_W-1:0]     fph_ff;
   logic [PH32_W-1:0]     cph_ff;
   logic [PH34_W-1:0]     wph_ff;
   logic                  active_ff;
   logic                  pass_ff;
   logic signed [SAMPLE_W-1:0] a_ff;
   logic signed [SAMPLE_W-1:0] sc_ff;
   logic [SAMPLE_W-2:0]   hann_ff;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic                  rsp_tvalid_ff;
   logic [SAMPLE_W-1:0]   rsp_data_ff;
   logic [CH_W-1:0]       rsp_user_ff;

   // per-channel phase state
   logic [PH34_W-1:0]     fph_mem_ff [CHANNELS];
   logic [PH32_W-1:0]     cph_mem_ff [CHANNELS];
   logic [PH34_W-1:0]     wph_mem_ff [CHANNELS];

   // request fields
   logic signed [FREQ_W-1:0] fund_s, cf_s, bw_s;
   logic [FREQ_W-2:0]        fund_c, bw_c;
   logic                     req_fire;

   // shared units
   logic                     mul_en;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic                     div_start;
   logic [DVD_W-1:0]         div_q;
   div_status_type           div_stat;
   logic [SINE_ADDR_W-1:0]   rom_addr;
   logic signed [SAMPLE_W-1:0] rom_q;

   // datapath helpers
   logic [PH32_W-1:0]        sine_ph;
   logic [SINE_ADDR_W-1:0]   sine_idx;
   logic [15:0]              sine_frac;
   logic signed [16:0]       diff;
   logic signed [PROD_W-1:0] interp_adj;
   logic signed [PROD_W-1:0] interp_step;
   logic signed [17:0]       sine_sum;
   logic signed [PROD_W-1:0] smp_full;
   logic [16:0]              hann_sum;
   logic [CH_IDX_W-1:0]      ch_idx;

   assign req_fire = req_tvalid && req_tready;
   assign ch_idx   = ch_ff[CH_IDX_W-1:0];

   // clamp fundamental, raise bandwidth; center is split into sign and magnitude on acceptance
   always_comb begin
      fund_s = req_tdata[23:0];
      cf_s   = req_tdata[47:24];
      bw_s   = req_tdata[71:48];
      fund_c = fund_s[FREQ_W-1] ? '0 : fund_s[FREQ_W-2:0];
      bw_c   = (bw_s < $signed({1'b0, fund_c})) ? fund_c : bw_s[FREQ_W-2:0];
   end

   // increment = (freq * inverse_rate) >> 8, capped at 1.0
   function automatic logic [INC_W-1:0] cap_inc(input logic [PROD_W-1:0] p);
      logic [PROD_W-9:0] t;
      t = p[PROD_W-1:8];
      return (t > (PROD_W-8)'(ONE_Q32)) ? INC_W'(ONE_Q32) : t[INC_W-1:0];
   endfunction

   // sine lookup: index from the top of the phase, 16-bit fraction below it
   always_comb begin
      sine_ph   = pass_ff ? cph_ff : (wph_ff[PH32_W-1:0] + HANN_OFFSET);
      sine_idx  = sine_ph[PH32_W-1 -: SINE_ADDR_W];
      sine_frac = sine_ph[PH32_W-1-SINE_ADDR_W -: 16];
      diff      = {rom_q[SAMPLE_W-1], rom_q} - {a_ff[SAMPLE_W-1], a_ff};
      // truncate the step toward zero
      interp_adj  = mul_p[PROD_W-1] ? (mul_p + PROD_W'(65535)) : mul_p;
      interp_step = interp_adj >>> 16;
      sine_sum    = 18'(a_ff) + interp_step[17:0];
      // sign-extended sine plus one half, always within 1..65535
      hann_sum    = 17'(sine_sum[16:0] + 17'sd32768);
      // round to Q15, ties upward
      smp_full    = (mul_p + PROD_W'(16384)) >>> 15;
   end

   // multiplier operands, divider start and ROM address by sequencer step
   always_comb begin
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      rom_addr  = sine_idx;
      case (state_ff)
         S_INC_F: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(fund_ff);
            mul_b  = MUL_W'(inv_rate_ff);
         end
         S_INC_B: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(bw_ff);
            mul_b  = MUL_W'(inv_rate_ff);
         end
         S_INC_C: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(cf_mag_ff);
            mul_b  = MUL_W'(inv_rate_ff);
         end
         S_WRAP: begin
            mul_en = (fph_ff > ONE_Q32) && (finc_ff != '0);
            mul_a  = MUL_W'(fph_ff[PH32_W-1:0]);
            mul_b  = MUL_W'(cinc_ff);
         end
         S_Q_START: begin
            div_start = 1'b1;
            mul_en    = 1'b1;
            mul_a     = MUL_W'(fph_ff[PH32_W-1:0]);
            mul_b     = MUL_W'(binc_ff);
         end
         S_W_START: begin
            div_start = 1'b1;
         end
         S_RD_B: begin
            rom_addr = sine_idx + 1'b1;
         end
         S_INTERP: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(diff);
            mul_b  = MUL_W'(sine_frac);
         end
         S_PROD: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(sc_ff);
            mul_b  = MUL_W'(hann_ff);
         end
         default: begin
         end
      endcase
   end

   // next step of the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_fire) state_in = S_INC_F;
         S_INC_F:   state_in = S_INC_B;
         S_INC_B:   state_in = S_INC_C;
         S_INC_C:   state_in = S_LOAD;
         S_LOAD:    state_in = ch_ok_ff ? S_WRAP : S_DONE;
         S_WRAP: begin
            if ((fph_ff > ONE_Q32) && (finc_ff != '0)) state_in = S_Q_START;
            else state_in = S_WIN;
         end
         S_Q_START: state_in = S_Q_WAIT;
         S_Q_WAIT:  if (div_stat.done) state_in = S_W_START;
         S_W_START: state_in = S_W_WAIT;
         S_W_WAIT:  if (div_stat.done) state_in = S_WIN;
         S_WIN:     state_in = (wph_ff < ONE_Q32) ? S_RD_A : S_UPDATE;
         S_RD_A:    state_in = S_RD_B;
         S_RD_B:    state_in = S_INTERP;
         S_INTERP:  state_in = S_SINE;
         S_SINE:    state_in = pass_ff ? S_PROD : S_RD_A;
         S_PROD:    state_in = S_SAMPLE;
         S_SAMPLE:  state_in = S_UPDATE;
         S_UPDATE:  state_in = S_DONE;
         S_DONE:    if (!rsp_tvalid_ff || rsp_tready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // state, datapath and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         inv_rate_ff   <= INV_RATE_RESET;
         rsp_tvalid_ff <= 1'b0;
         for (int k = 0; k < CHANNELS; k++) begin
            fph_mem_ff[k] <= ONE_Q32;
            cph_mem_ff[k] <= '0;
            wph_mem_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            inv_rate_ff <= csr_wdata;
         end
         // the done step reloads the output register itself
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  ch_ff     <= req_tuser;
                  ch_ok_ff  <= (32'(req_tuser) < CHANNELS);
                  fund_ff   <= fund_c;
                  bw_ff     <= bw_c;
                  cf_neg_ff <= cf_s[FREQ_W-1];
                  cf_mag_ff <= cf_s[FREQ_W-1] ? (~req_tdata[47:24] + 1'b1) : req_tdata[47:24];
               end
            end
            S_INC_B: finc_ff <= cap_inc(mul_p);
            S_INC_C: binc_ff <= cap_inc(mul_p);
            S_LOAD: begin
               cinc_ff   <= cap_inc(mul_p);
               sample_ff <= '0;
               fph_ff    <= fph_mem_ff[ch_idx];
               cph_ff    <= cph_mem_ff[ch_idx];
               wph_ff    <= wph_mem_ff[ch_idx];
            end
            S_WRAP: begin
               if (fph_ff > ONE_Q32) begin
                  fph_ff <= {2'b00, fph_ff[PH32_W-1:0]};
                  if (finc_ff == '0) begin
                     cph_ff <= '0;
                     wph_ff <= PHASE34_MAX;
                  end
               end
            end
            S_Q_WAIT: begin
               if (div_stat.done) begin
                  cph_ff <= cf_neg_ff ? (PH32_W'(0) - div_q[PH32_W-1:0]) : div_q[PH32_W-1:0];
               end
            end
            S_W_WAIT: begin
               if (div_stat.done) begin
                  wph_ff <= (|div_q[DVD_W-1:PH34_W]) ? PHASE34_MAX : div_q[PH34_W-1:0];
               end
            end
            S_WIN: begin
               pass_ff   <= 1'b0;
               active_ff <= (wph_ff < ONE_Q32);
            end
            S_RD_B: a_ff <= rom_q;
            S_SINE: begin
               if (!pass_ff) begin
                  hann_ff <= hann_sum[15:1];
                  pass_ff <= 1'b1;
               end else begin
                  sc_ff <= sine_sum[15:0];
               end
            end
            S_SAMPLE: begin
               if (smp_full > PROD_W'(32767)) sample_ff <= 16'sd32767;
               else if (smp_full < -PROD_W'(32767)) sample_ff <= -16'sd32767;
               else sample_ff <= smp_full[SAMPLE_W-1:0];
            end
            S_UPDATE: begin
               fph_mem_ff[ch_idx] <= fph_ff + PH34_W'(finc_ff);
               cph_mem_ff[ch_idx] <= cf_neg_ff ? (cph_ff - cinc_ff[PH32_W-1:0])
                                               : (cph_ff + cinc_ff[PH32_W-1:0]);
               wph_mem_ff[ch_idx] <= active_ff ? (wph_ff + PH34_W'(binc_ff)) : wph_ff;
            end
            S_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_data_ff   <= sample_ff;
                  rsp_user_ff   <= ch_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   fgo_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .mul_p  (mul_p)
   );

   fgo_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (mul_p[DVD_W-1:0]),
      .div_divisor  (finc_ff),
      .div_quotient (div_q),
      .div_stat     (div_stat)
   );

   fgo_sine_rom u_rom (
      .clock    (clock),
      .rom_addr (rom_addr),
      .rom_q    (rom_q)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new transaction accepted while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_DONE))
      else $error("result presented outside the done step");

endmodule
